// ===== src/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, codes and types of the MIPS subset executor.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned DATA_WORDS_DEF = 16384;
  localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LB    = 6'd32;
  localparam logic [5:0] OP_LH    = 6'd33;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_LBU   = 6'd36;
  localparam logic [5:0] OP_LHU   = 6'd37;
  localparam logic [5:0] OP_SB    = 6'd40;
  localparam logic [5:0] OP_SH    = 6'd41;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_SRL = 6'd2;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // What the second stage has left to do
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_REG,
    KIND_MEM
  } kind_t;

  // Request state handed from the execute stage to the memory stage
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    kind_t       kind;
    logic [5:0]  op;
    logic [1:0]  lo;
    logic [29:0] widx;
    logic [4:0]  dst;
    logic [31:0] val;
    logic [31:0] sdata;
  } e2_t;

endpackage

// ===== src/mse_regfile.sv =====
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Valid bits give the all-zero reset; a same-edge write is forwarded.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        re,
  input  logic [4:0]  ra_a,
  input  logic [4:0]  ra_b,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b
);

  logic [31:0] mem [32];
  logic [31:0] valid_r;
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wa] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read ports, write-first on a same-entry collision
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_r <= (we && wa == ra_a) ? wd : (valid_r[ra_a] ? mem[ra_a] : '0);
      rd_b_r <= (we && wa == ra_b) ? wd : (valid_r[ra_b] ? mem[ra_b] : '0);
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== src/mse_dmem.sv =====
// ----------------------------------------------------------------------------
// mse_dmem
// Word data memory with one registered read port and one write port.
// After reset a clearing pass fills every word with all ones.
// ----------------------------------------------------------------------------
module mse_dmem #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF,
  parameter int unsigned AW         = $clog2(DATA_WORDS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata,
  output logic          busy
);

  localparam logic [AW-1:0] LAST = AW'(DATA_WORDS - 1);

  logic [31:0]   mem [DATA_WORDS];
  logic [31:0]   rdata_r;
  logic          busy_r;
  logic [AW-1:0] cnt_r;

  // Sweep the clearing counter once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Write port, shared with the clearing pass
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[cnt_r] <= '1;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, write-first on a same-word collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

// ===== src/mse_exec.sv =====
// ----------------------------------------------------------------------------
// mse_exec
// Execute stage: decode, ALU, branch and jump target, effective address
// and range check. Pure combinational logic.
// ----------------------------------------------------------------------------
module mse_exec #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic [31:0]  instr,
  input  logic [31:0]  pc,
  input  logic [31:0]  a,
  input  logic [31:0]  b,
  input  logic [31:0]  base,
  output mse_pkg::e2_t res
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  shamt;
  logic [31:0] simm;
  logic [31:0] uimm;
  logic [31:0] pc_adv;
  logic [31:0] off;
  logic        in_range;

  assign op       = instr[31:26];
  assign rt       = instr[20:16];
  assign rd       = instr[15:11];
  assign shamt    = instr[10:6];
  assign fn       = instr[5:0];
  assign simm     = {{16{instr[15]}}, instr[15:0]};
  assign uimm     = {16'd0, instr[15:0]};
  assign pc_adv   = pc + 32'd4;
  assign off      = a + simm - base;
  assign in_range = off[31:2] < 30'(DATA_WORDS);

  // Decode and execute
  always_comb begin
    res         = '0;
    res.status  = mse_pkg::ST_OK;
    res.next_pc = pc_adv;
    res.kind    = mse_pkg::KIND_NONE;
    res.op      = op;
    res.lo      = off[1:0];
    res.widx    = off[31:2];
    res.sdata   = b;
    case (op)
      mse_pkg::OP_RTYPE: begin
        res.kind = mse_pkg::KIND_REG;
        res.dst  = rd;
        case (fn)
          mse_pkg::FN_ADD: res.val = a + b;
          mse_pkg::FN_SUB: res.val = a - b;
          mse_pkg::FN_AND: res.val = a & b;
          mse_pkg::FN_OR:  res.val = a | b;
          mse_pkg::FN_SLL: res.val = b << shamt;
          mse_pkg::FN_SRL: res.val = b >> shamt;
          mse_pkg::FN_SLT: res.val = {31'd0, $signed(a) < $signed(b)};
          default: begin
            res.kind   = mse_pkg::KIND_NONE;
            res.status = mse_pkg::ST_UNKNOWN;
          end
        endcase
      end
      mse_pkg::OP_J: begin
        res.next_pc = {pc_adv[31:28], instr[25:0], 2'b00};
      end
      mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
        if ((a == b) == (op == mse_pkg::OP_BEQ)) begin
          res.next_pc = pc_adv + {simm[29:0], 2'b00};
        end
      end
      mse_pkg::OP_ADDI, mse_pkg::OP_SLTI, mse_pkg::OP_ANDI,
      mse_pkg::OP_ORI, mse_pkg::OP_LUI: begin
        res.kind = mse_pkg::KIND_REG;
        res.dst  = rt;
        case (op)
          mse_pkg::OP_ADDI: res.val = a + simm;
          mse_pkg::OP_ANDI: res.val = a & uimm;
          mse_pkg::OP_ORI:  res.val = a | uimm;
          mse_pkg::OP_LUI:  res.val = {instr[15:0], 16'd0};
          default:          res.val = {31'd0, $signed(a) < $signed(simm)};
        endcase
      end
      mse_pkg::OP_LB, mse_pkg::OP_LH, mse_pkg::OP_LW, mse_pkg::OP_LBU,
      mse_pkg::OP_LHU, mse_pkg::OP_SB, mse_pkg::OP_SH, mse_pkg::OP_SW: begin
        res.dst = rt;
        if (in_range) begin
          res.kind = mse_pkg::KIND_MEM;
        end else begin
          res.status = mse_pkg::ST_RANGE;
        end
      end
      default: begin
        res.status = mse_pkg::ST_UNKNOWN;
      end
    endcase
  end

endmodule

// ===== src/mips_subset_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// Executes a MIPS32 subset, one instruction word per request.
// ----------------------------------------------------------------------------
// A request enters the execute stage (register file read, ALU, address),
// then the memory stage (data word read, load extract or store merge,
// write back) and lands in the output register, where the result becomes
// valid; a new request may be accepted every cycle while results are taken,
// since register and memory results are forwarded to the following request.
// After reset the data memory is filled with all ones, one word per cycle,
// and no request is accepted until the pass has covered all DATA_WORDS
// words; data_base_address may be written during that time.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
  parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_next_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_reg_number,
  output logic [31:0] out_reg_value,
  output logic        out_mem_written,
  output logic [13:0] out_mem_word_index,
  output logic [31:0] out_mem_word_value
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [31:0]  base_r;
  logic [31:0]  pc_r;
  logic         e1_v_r;
  logic [31:0]  e1_instr_r;
  logic         e2_v_r;
  mse_pkg::e2_t e2_r;
  mse_pkg::e2_t exec_res;
  logic         out_v_r;
  logic [1:0]   o_status_r;
  logic [31:0]  o_pc_r;
  logic         o_rw_r;
  logic [4:0]   o_rn_r;
  logic [31:0]  o_rv_r;
  logic         o_mw_r;
  logic [13:0]  o_mi_r;
  logic [31:0]  o_mv_r;

  logic         accept;
  logic         e1_move;
  logic         e2_go;
  logic         clr_busy;
  logic [31:0]  rf_a;
  logic [31:0]  rf_b;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [31:0]  word;
  logic [7:0]   byte_sel;
  logic         wreg;
  logic         wmem;
  logic [31:0]  wval;
  logic [31:0]  mval;

  // Handshake and stage advance
  assign e2_go    = e2_v_r && (!out_v_r || !out_stall);
  assign e1_move  = e1_v_r && (!e2_v_r || e2_go);
  assign in_stall = clr_busy || (e1_v_r && !e1_move);
  assign accept   = in_valid && !in_stall;

  mse_regfile u_rf (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept),
    .ra_a  (in_instruction_word[25:21]),
    .ra_b  (in_instruction_word[20:16]),
    .we    (e2_go && wreg),
    .wa    (e2_r.dst),
    .wd    (wval),
    .rd_a  (rf_a),
    .rd_b  (rf_b)
  );

  // Forward the memory stage's pending register write
  assign op_a = (e2_v_r && wreg && e2_r.dst == e1_instr_r[25:21]) ? wval : rf_a;
  assign op_b = (e2_v_r && wreg && e2_r.dst == e1_instr_r[20:16]) ? wval : rf_b;

  mse_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
    .instr (e1_instr_r),
    .pc    (pc_r),
    .a     (op_a),
    .b     (op_b),
    .base  (base_r),
    .res   (exec_res)
  );

  mse_dmem #(.DATA_WORDS(DATA_WORDS), .AW(AW)) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (e1_move),
    .raddr (exec_res.widx[AW-1:0]),
    .we    (e2_go && wmem),
    .waddr (e2_r.widx[AW-1:0]),
    .wdata (mval),
    .rdata (word),
    .busy  (clr_busy)
  );

  // Pick the addressed byte, big-endian
  always_comb begin
    case (e2_r.lo)
      2'd0:    byte_sel = word[31:24];
      2'd1:    byte_sel = word[23:16];
      2'd2:    byte_sel = word[15:8];
      default: byte_sel = word[7:0];
    endcase
  end

  // Finish loads and merge stores
  always_comb begin
    wreg = 1'b0;
    wmem = 1'b0;
    wval = e2_r.val;
    mval = e2_r.sdata;
    case (e2_r.kind)
      mse_pkg::KIND_REG: wreg = 1'b1;
      mse_pkg::KIND_MEM: begin
        case (e2_r.op)
          mse_pkg::OP_LB: begin
            wreg = 1'b1;
            wval = {{24{byte_sel[7]}}, byte_sel};
          end
          mse_pkg::OP_LBU: begin
            wreg = 1'b1;
            wval = {24'd0, byte_sel};
          end
          mse_pkg::OP_LH: begin
            wreg = !e2_r.lo[0];
            wval = e2_r.lo[1] ? {{16{word[15]}}, word[15:0]}
                              : {{16{word[31]}}, word[31:16]};
          end
          mse_pkg::OP_LHU: begin
            wreg = !e2_r.lo[0];
            wval = e2_r.lo[1] ? {16'd0, word[15:0]} : {16'd0, word[31:16]};
          end
          mse_pkg::OP_LW: begin
            wreg = 1'b1;
            wval = word;
          end
          mse_pkg::OP_SB: begin
            wmem = 1'b1;
            case (e2_r.lo)
              2'd0:    mval = {e2_r.sdata[7:0], word[23:0]};
              2'd1:    mval = {word[31:24], e2_r.sdata[7:0], word[15:0]};
              2'd2:    mval = {word[31:16], e2_r.sdata[7:0], word[7:0]};
              default: mval = {word[31:8], e2_r.sdata[7:0]};
            endcase
          end
          mse_pkg::OP_SH: begin
            wmem = !e2_r.lo[0];
            mval = e2_r.lo[1] ? {word[31:16], e2_r.sdata[15:0]}
                              : {e2_r.sdata[15:0], word[15:0]};
          end
          mse_pkg::OP_SW: wmem = 1'b1;
          default: wmem = 1'b0;
        endcase
      end
      default: wreg = 1'b0;
    endcase
    // Drop writes to register zero
    if (e2_r.dst == 5'd0) begin
      wreg = 1'b0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= mse_pkg::DATA_BASE_RST;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // Control state: pc and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      e1_v_r  <= 1'b0;
      e2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (e1_move) begin
        pc_r <= exec_res.next_pc;
      end
      if (accept) begin
        e1_v_r <= 1'b1;
      end else if (e1_move) begin
        e1_v_r <= 1'b0;
      end
      if (e1_move) begin
        e2_v_r <= 1'b1;
      end else if (e2_go) begin
        e2_v_r <= 1'b0;
      end
      if (e2_go) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload: advance stage registers
  always_ff @(posedge clk) begin
    if (accept) begin
      e1_instr_r <= in_instruction_word;
    end
    if (e1_move) begin
      e2_r <= exec_res;
    end
    if (e2_go) begin
      o_status_r <= e2_r.status;
      o_pc_r     <= e2_r.next_pc;
      o_rw_r     <= wreg;
      o_rn_r     <= wreg ? e2_r.dst : 5'd0;
      o_rv_r     <= wreg ? wval : 32'd0;
      o_mw_r     <= wmem;
      o_mi_r     <= wmem ? 14'(e2_r.widx) : 14'd0;
      o_mv_r     <= wmem ? mval : 32'd0;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = o_status_r;
  assign out_next_pc        = o_pc_r;
  assign out_reg_written    = o_rw_r;
  assign out_reg_number     = o_rn_r;
  assign out_reg_value      = o_rv_r;
  assign out_mem_written    = o_mw_r;
  assign out_mem_word_index = o_mi_r;
  assign out_mem_word_value = o_mv_r;

  // No request enters while the data memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept) else $error("request accepted during clearing pass");

  // Register zero is never written back
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (e2_go && wreg) |-> e2_r.dst != 5'd0) else $error("write to register zero");

  // A flagged result writes neither a register nor memory
  a_flag_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_status_r != mse_pkg::ST_OK) |-> (!o_rw_r && !o_mw_r))
    else $error("flagged result reports a write");

  // A request that leaves the memory stage shows up at the output next cycle
  a_e2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    e2_go |=> out_v_r) else $error("completed request lost");

endmodule
